// ----- hdl/vlisqrt_pkg.sv -----
// vlisqrt_pkg: shared constants for the vector length square root pipeline
// no dependencies; imported by vlisqrt_step and vector_length_integer_sqrt
`default_nettype none
package vlisqrt_pkg;

	// radicand bits consumed per root digit
	localparam int unsigned DIGIT_BITS = 2;

	// register stages ahead of the root chain: magnitude, square, sum
	localparam int unsigned FRONT_STAGES = 3;

endpackage
`default_nettype wire

// ----- hdl/vlisqrt_front.sv -----
// vlisqrt_front: magnitude, square and sum stages of the vector length pipeline
// no package dependencies; feeds the vlisqrt_step chain
`default_nettype none
module vlisqrt_front #(
	parameter int unsigned COORD_BITS = 13
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire signed [COORD_BITS-1:0]  delta_x,
	input  wire signed [COORD_BITS-1:0]  delta_y,
	output logic                         out_valid,
	output logic [2*COORD_BITS-1:0]      sum
);

	localparam int unsigned SUM_BITS = 2 * COORD_BITS;

	logic [COORD_BITS-1:0] raw_x;
	logic [COORD_BITS-1:0] raw_y;
	logic [COORD_BITS-1:0] mag_x;
	logic [COORD_BITS-1:0] mag_y;

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic [COORD_BITS-1:0] mag_x_s1;
	logic [COORD_BITS-1:0] mag_y_s1;
	logic [SUM_BITS-1:0]   sq_x_s2;
	logic [SUM_BITS-1:0]   sq_y_s2;
	logic [SUM_BITS-1:0]   sum_s3;

	// magnitude of each component, the most negative value maps to 2^(n-1)
	always_comb begin
		raw_x = delta_x;
		raw_y = delta_y;
		mag_x = raw_x[COORD_BITS-1] ? COORD_BITS'(0) - raw_x : raw_x;
		mag_y = raw_y[COORD_BITS-1] ? COORD_BITS'(0) - raw_y : raw_y;
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload: magnitudes, squares, sum of squares
	always_ff @(posedge clk) begin
		mag_x_s1 <= mag_x;
		mag_y_s1 <= mag_y;
		sq_x_s2  <= SUM_BITS'(mag_x_s1) * SUM_BITS'(mag_x_s1);
		sq_y_s2  <= SUM_BITS'(mag_y_s1) * SUM_BITS'(mag_y_s1);
		sum_s3   <= sq_x_s2 + sq_y_s2;
	end

	assign out_valid = valid_s3;
	assign sum       = sum_s3;

endmodule
`default_nettype wire

// ----- hdl/vlisqrt_step.sv -----
// vlisqrt_step: one registered digit of the restoring square root
// depends on vlisqrt_pkg for the digit width
`default_nettype none
module vlisqrt_step #(
	parameter int unsigned COORD_BITS = 13,
	parameter int unsigned STEP       = 0
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	input  wire  [2*COORD_BITS-1:0]   in_sum,
	input  wire  [COORD_BITS-1:0]     in_root,
	input  wire  [COORD_BITS:0]       in_rem,
	output logic                      out_valid,
	output logic [2*COORD_BITS-1:0]   out_sum,
	output logic [COORD_BITS-1:0]     out_root,
	output logic [COORD_BITS:0]       out_rem
);
	import vlisqrt_pkg::*;

	localparam int unsigned REM_BITS  = COORD_BITS + 1;
	localparam int unsigned WIDE_BITS = REM_BITS + DIGIT_BITS;

	logic [WIDE_BITS-1:0]  shifted;
	logic [WIDE_BITS-1:0]  trial;
	logic                  fits;
	logic [WIDE_BITS-1:0]  diff;
	logic [REM_BITS-1:0]   rem_next;
	logic [COORD_BITS-1:0] root_next;

	logic                  valid_s1;
	logic [2*COORD_BITS-1:0] sum_s1;
	logic [COORD_BITS-1:0] root_s1;
	logic [REM_BITS-1:0]   rem_s1;

	// bring down the next two radicand bits and try root*4+1
	always_comb begin
		shifted   = {in_rem, in_sum[DIGIT_BITS*STEP +: DIGIT_BITS]};
		trial     = WIDE_BITS'({in_root, 2'b01});
		fits      = shifted >= trial;
		diff      = shifted - trial;
		rem_next  = fits ? REM_BITS'(diff) : REM_BITS'(shifted);
		root_next = {in_root[COORD_BITS-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1  <= in_sum;
		root_s1 <= root_next;
		rem_s1  <= rem_next;
	end

	assign out_valid = valid_s1;
	assign out_sum   = sum_s1;
	assign out_root  = root_s1;
	assign out_rem   = rem_s1;

endmodule
`default_nettype wire

// ----- hdl/vector_length_integer_sqrt.sv -----
// vector_length_integer_sqrt: floor(sqrt(dx*dx+dy*dy)) as a fully pipelined datapath
// 3 front stages, then one root digit per stage
// throughput one vector per cycle; busy is always low and done strobes one cycle per result
// the receiver cannot stall, so the pipeline advances every cycle
// reset clears all valid bits; payload registers are not reset
// depends on vlisqrt_pkg, vlisqrt_front and vlisqrt_step
`default_nettype none
module vector_length_integer_sqrt #(
	parameter int unsigned COORD_BITS = 13
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire signed [COORD_BITS-1:0]  delta_x,
	input  wire signed [COORD_BITS-1:0]  delta_y,
	output logic                         done,
	output logic [COORD_BITS-1:0]        vector_length
);
	import vlisqrt_pkg::*;

	localparam int unsigned SUM_BITS = 2 * COORD_BITS;
	localparam int unsigned REM_BITS = COORD_BITS + 1;
	localparam int unsigned LATENCY  = FRONT_STAGES + COORD_BITS;

	logic                  valid_w [COORD_BITS+1];
	logic [SUM_BITS-1:0]   sum_w   [COORD_BITS+1];
	logic [COORD_BITS-1:0] root_w  [COORD_BITS+1];
	logic [REM_BITS-1:0]   rem_w   [COORD_BITS+1];

	// every cycle takes a transfer
	assign busy = 1'b0;

	// magnitude, square and sum
	vlisqrt_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.delta_x  (delta_x),
		.delta_y  (delta_y),
		.out_valid(valid_w[0]),
		.sum      (sum_w[0])
	);

	assign root_w[0] = '0;
	assign rem_w[0]  = '0;

	// root chain, most significant digit first
	for (genvar g = 0; g < COORD_BITS; g++) begin : g_step
		vlisqrt_step #(
			.COORD_BITS(COORD_BITS),
			.STEP      (COORD_BITS - 1 - g)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_w[g]),
			.in_sum   (sum_w[g]),
			.in_root  (root_w[g]),
			.in_rem   (rem_w[g]),
			.out_valid(valid_w[g+1]),
			.out_sum  (sum_w[g+1]),
			.out_root (root_w[g+1]),
			.out_rem  (rem_w[g+1])
		);
	end

	assign done          = valid_w[COORD_BITS];
	assign vector_length = root_w[COORD_BITS];

`ifndef SYNTHESIS
	// result is the floor root of the sum it was computed from
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((SUM_BITS + 2)'(vector_length) * (SUM_BITS + 2)'(vector_length)
			<= (SUM_BITS + 2)'(sum_w[COORD_BITS])))
		else $error("root squared exceeds radicand");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (((SUM_BITS + 2)'(vector_length) + 1'b1)
			* ((SUM_BITS + 2)'(vector_length) + 1'b1)
			> (SUM_BITS + 2)'(sum_w[COORD_BITS])))
		else $error("root is not the floor root");

	// a transfer in gives a strobe when it leaves the last root stage, and none comes without one
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted vector lost in pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done)
		else $error("result strobe without accepted vector");

	// zero vector gives zero length
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && delta_x == '0 && delta_y == '0) |-> ##LATENCY (vector_length == '0))
		else $error("zero vector gave nonzero length");
`endif

endmodule
`default_nettype wire
